// File: rtl/mbp_pkg.sv
// Shared constants, state encoding and divider control types for the mesh block partitioner.
package mbp_pkg;

   localparam int MAX_CHUNKS = 1024;
   localparam int CELL_BITS  = 16;
   localparam int CHUNK_W    = 11;
   localparam int TASK_W     = 10;
   localparam int NEAR_W     = 12;
   localparam int SQ_W       = 2 * (CHUNK_W - 1) + 1;
   localparam int NY_W       = CHUNK_W + CELL_BITS;
   localparam int PROD_W     = SQ_W + CELL_BITS;
   localparam int DIV_STEPS  = CELL_BITS;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [NEAR_W-1:0] NEAR_EXTERNAL = '1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_NY,
      S_SQX,
      S_CMP,
      S_DIVC,
      S_PICK,
      S_CHK,
      S_DX,
      S_DY,
      S_DT,
      S_ML,
      S_MB,
      S_MG,
      S_FIN,
      S_OUT
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [CELL_BITS-1:0] dividend;
      logic [CHUNK_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [CELL_BITS-1:0] quotient;
      logic [CHUNK_W-1:0]   remainder;
   } div_rsp_type;

endpackage

// File: rtl/mbp_req_if.sv
// Request channel: mesh size and task index.
interface mbp_req_if;
   import mbp_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CELL_BITS-1:0] mesh_width;
   logic [CELL_BITS-1:0] mesh_height;
   logic [TASK_W-1:0]    task_index;

   modport source (output valid, output mesh_width, output mesh_height,
                   output task_index, input ready);
   modport sink (input valid, input mesh_width, input mesh_height,
                 input task_index, output ready);
endinterface

// File: rtl/mbp_rsp_if.sv
// Response channel: chunk cell range, neighbours and chosen grid.
interface mbp_rsp_if;
   import mbp_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [CELL_BITS-1:0]     range_left;
   logic [CELL_BITS-1:0]     range_right;
   logic [CELL_BITS-1:0]     range_bottom;
   logic [CELL_BITS-1:0]     range_top;
   logic signed [NEAR_W-1:0] near_left;
   logic signed [NEAR_W-1:0] near_right;
   logic signed [NEAR_W-1:0] near_bottom;
   logic signed [NEAR_W-1:0] near_top;
   logic [CHUNK_W-1:0]       grid_cols;
   logic [CHUNK_W-1:0]       grid_rows;
   logic                     task_ok;

   modport source (output valid, output range_left, output range_right,
                   output range_bottom, output range_top, output near_left,
                   output near_right, output near_bottom, output near_top,
                   output grid_cols, output grid_rows, output task_ok, input ready);
   modport sink (input valid, input range_left, input range_right,
                 input range_bottom, input range_top, input near_left,
                 input near_right, input near_bottom, input near_top,
                 input grid_cols, input grid_rows, input task_ok, output ready);
endinterface

// File: rtl/mbp_csr_if.sv
// Configuration write channel carrying the chunk count.
interface mbp_csr_if;
   import mbp_pkg::*;

   logic               valid;
   logic               ready;
   logic [CHUNK_W-1:0] chunk_count;

   modport source (output valid, output chunk_count, input ready);
   modport sink (input valid, input chunk_count, output ready);
endinterface

// File: rtl/mbp_div.sv
// Restoring divider, one quotient bit per cycle, shared by the partition sequencer.
module mbp_div (
   input  logic                clock,
   input  logic                reset,
   input  mbp_pkg::div_req_type req,
   output mbp_pkg::div_rsp_type rsp
);
   import mbp_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [CHUNK_W-1:0]   rem_ff, rem_in;
   logic [CELL_BITS-1:0] quo_ff, quo_in;
   logic [CHUNK_W-1:0]   dsr_ff, dsr_in;

   logic [CHUNK_W:0]     trial;
   logic [CHUNK_W:0]     diff;
   logic                 fits;

   always_comb begin
      trial = {rem_ff, quo_ff[CELL_BITS-1]};
      fits  = trial >= {1'b0, dsr_ff};
      diff  = trial - {1'b0, dsr_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;

      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = req.dividend;
         dsr_in  = req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[CHUNK_W-1:0] : trial[CHUNK_W-1:0];
         quo_in = {quo_ff[CELL_BITS-2:0], fits};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

`ifndef NO_ASSERTIONS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff)
      else $error("divider started while busy");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      req.start |=> busy_ff)
      else $error("divider did not go busy after start");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held longer than one cycle");
`endif

endmodule

// File: rtl/mesh_block_partition.sv
// Mesh block partitioner: splits a mesh into chunk_count chunks and reports one task's chunk.
//
// Usage:
//   csr_bus  : write chunk_count (always ready). Write only while no request is in flight.
//              Zero counts as one chunk; values above 1024 count as 1024.
//   req_bus  : mesh_width, mesh_height, task_index. Ready only while the sequencer is idle.
//   rsp_bus  : cell range, four neighbour chunk numbers (-1 at an external face), grid and
//              task_ok. The response sits in an output register until taken.
// Timing:
//   The divisor search runs on one shared multiplier and one shared 16-step divider.
//   N*y is formed first, then each candidate's square is multiplied by x and compared, up
//   to the first one that meets the aspect threshold; from there each candidate costs one
//   division of the chunk count. The tail runs three divisions, three multiplies and the
//   control states S_PICK, S_CHK, S_FIN and S_OUT. Once a response is loaded, the
//   sequencer returns to idle and takes the next request in the cycle after the load.
//   A task at or above the chunk count skips the tail divisions and multiplies.
// Reset: chunk_count returns to 1, the sequencer goes idle and the response is dropped.
// Stall: a held response does not block the next request; a finished response waits in
//   the sequencer until the output register frees up.
module mesh_block_partition (
   input  logic          clock,
   input  logic          reset,
   mbp_req_if.sink       req_bus,
   mbp_rsp_if.source     rsp_bus,
   mbp_csr_if.sink       csr_bus
);
   import mbp_pkg::*;

   state_type state_ff, state_in;

   logic [CHUNK_W-1:0]   chunk_ff;

   logic [CELL_BITS-1:0] x_ff, x_in;
   logic [CELL_BITS-1:0] y_ff, y_in;
   logic [TASK_W-1:0]    t_ff, t_in;
   logic [CHUNK_W-1:0]   n_ff, n_in;
   logic [CHUNK_W-1:0]   c_ff, c_in;
   logic [SQ_W-1:0]      sq_ff, sq_in;
   logic [NY_W-1:0]      ny_ff, ny_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic                 found_ff, found_in;
   logic [CHUNK_W-1:0]   gx_ff, gx_in;
   logic [CHUNK_W-1:0]   gy_ff, gy_in;
   logic                 ok_ff, ok_in;
   logic [CELL_BITS-1:0] dx_ff, dx_in;
   logic [CELL_BITS-1:0] dy_ff, dy_in;
   logic [CHUNK_W-1:0]   mx_ff, mx_in;
   logic [CHUNK_W-1:0]   my_ff, my_in;
   logic [TASK_W-1:0]    q_ff, q_in;
   logic [TASK_W-1:0]    r_ff, r_in;
   logic [CELL_BITS-1:0] left_ff, left_in;
   logic [CELL_BITS-1:0] bottom_ff, bottom_in;
   logic [NEAR_W-1:0]    base_ff, base_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CELL_BITS-1:0] o_left_ff, o_right_ff, o_bottom_ff, o_top_ff;
   logic [NEAR_W-1:0]    o_nl_ff, o_nr_ff, o_nb_ff, o_nt_ff;
   logic [CHUNK_W-1:0]   o_cols_ff, o_rows_ff;
   logic                 o_ok_ff;

   logic                 accept;
   logic                 req_ready;
   logic                 rsp_load;
   logic [CHUNK_W-1:0]   n_clamp;
   logic [SQ_W-1:0]      mul_a;
   logic [CELL_BITS-1:0] mul_b;
   logic [PROD_W-1:0]    mul_p;
   logic                 cond;
   logic                 t_lt_n;
   div_req_type          div_req;
   div_rsp_type          div_rsp;

   logic [CHUNK_W-1:0]   min_x, min_y;
   logic [CELL_BITS-1:0] right_val, top_val;
   logic [NEAR_W-1:0]    nl_val, nr_val, nb_val, nt_val;

   mbp_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign accept  = req_bus.valid && req_ready;
   assign n_clamp = (chunk_ff == '0) ? CHUNK_W'(1) :
                    (chunk_ff > CHUNK_W'(MAX_CHUNKS)) ? CHUNK_W'(MAX_CHUNKS) : chunk_ff;
   assign mul_p   = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign cond    = PROD_W'(ny_ff) <= prod_ff;
   assign t_lt_n  = {1'b0, t_ff} < n_ff;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept) state_in = S_NY;
         S_NY:   state_in = S_SQX;
         S_SQX:  state_in = S_CMP;
         S_CMP: begin
            if (cond)               state_in = S_DIVC;
            else if (c_ff == n_ff)  state_in = S_PICK;
            else                    state_in = S_SQX;
         end
         S_DIVC: if (div_rsp.done && div_rsp.remainder == '0) state_in = S_PICK;
         S_PICK: state_in = S_CHK;
         S_CHK:  state_in = t_lt_n ? S_DX : S_OUT;
         S_DX:   if (div_rsp.done) state_in = S_DY;
         S_DY:   if (div_rsp.done) state_in = S_DT;
         S_DT:   if (div_rsp.done) state_in = S_ML;
         S_ML:   state_in = S_MB;
         S_MB:   state_in = S_MG;
         S_MG:   state_in = S_FIN;
         S_FIN:  state_in = S_OUT;
         S_OUT:  if (rsp_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer outputs: handshake, multiplier operands, divider requests
   always_comb begin
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      div_req   = '0;
      unique case (state_ff)
         S_IDLE: req_ready = 1'b1;
         S_NY: begin
            mul_a = SQ_W'(n_ff);
            mul_b = y_ff;
         end
         S_SQX: begin
            mul_a = sq_ff;
            mul_b = x_ff;
         end
         S_CMP: begin
            if (cond) begin
               div_req.start    = 1'b1;
               div_req.dividend = CELL_BITS'(n_ff);
               div_req.divisor  = c_ff;
            end
         end
         S_DIVC: begin
            // next candidate as soon as this one leaves a remainder
            if (div_rsp.done && div_rsp.remainder != '0) begin
               div_req.start    = 1'b1;
               div_req.dividend = CELL_BITS'(n_ff);
               div_req.divisor  = c_ff + CHUNK_W'(1);
            end
         end
         S_PICK: ;
         S_CHK: begin
            if (t_lt_n) begin
               div_req.start    = 1'b1;
               div_req.dividend = x_ff;
               div_req.divisor  = gx_ff;
            end
         end
         S_DX: begin
            if (div_rsp.done) begin
               div_req.start    = 1'b1;
               div_req.dividend = y_ff;
               div_req.divisor  = gy_ff;
            end
         end
         S_DY: begin
            if (div_rsp.done) begin
               div_req.start    = 1'b1;
               div_req.dividend = CELL_BITS'(t_ff);
               div_req.divisor  = gx_ff;
            end
         end
         S_DT: ;
         S_ML: begin
            mul_a = SQ_W'(r_ff);
            mul_b = dx_ff;
         end
         S_MB: begin
            mul_a = SQ_W'(q_ff);
            mul_b = dy_ff;
         end
         S_MG: begin
            mul_a = SQ_W'(gx_ff);
            mul_b = CELL_BITS'(q_ff);
         end
         S_FIN: ;
         S_OUT: rsp_load = !rsp_valid_ff || rsp_bus.ready;
         default: ;
      endcase
   end

   // final result fields
   always_comb begin
      min_x     = ({1'b0, r_ff} < mx_ff) ? {1'b0, r_ff} : mx_ff;
      min_y     = ({1'b0, q_ff} < my_ff) ? {1'b0, q_ff} : my_ff;
      right_val = left_ff + dx_ff + CELL_BITS'({1'b0, r_ff} < mx_ff) - CELL_BITS'(1);
      top_val   = bottom_ff + dy_ff + CELL_BITS'({1'b0, q_ff} < my_ff) - CELL_BITS'(1);
      nl_val    = (r_ff == '0) ? NEAR_EXTERNAL : base_ff - NEAR_W'(1);
      nr_val    = ({1'b0, r_ff} + CHUNK_W'(1) == gx_ff) ? NEAR_EXTERNAL :
                  base_ff + NEAR_W'(1);
      nb_val    = (q_ff == '0) ? NEAR_EXTERNAL : base_ff - NEAR_W'(gx_ff);
      nt_val    = ({1'b0, q_ff} + CHUNK_W'(1) == gy_ff) ? NEAR_EXTERNAL :
                  base_ff + NEAR_W'(gx_ff);
   end

   // datapath registers
   always_comb begin
      x_in      = x_ff;
      y_in      = y_ff;
      t_in      = t_ff;
      n_in      = n_ff;
      c_in      = c_ff;
      sq_in     = sq_ff;
      ny_in     = ny_ff;
      prod_in   = prod_ff;
      found_in  = found_ff;
      gx_in     = gx_ff;
      gy_in     = gy_ff;
      ok_in     = ok_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      mx_in     = mx_ff;
      my_in     = my_ff;
      q_in      = q_ff;
      r_in      = r_ff;
      left_in   = left_ff;
      bottom_in = bottom_ff;
      base_in   = base_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               x_in     = req_bus.mesh_width;
               y_in     = req_bus.mesh_height;
               t_in     = req_bus.task_index;
               n_in     = n_clamp;
               c_in     = CHUNK_W'(1);
               sq_in    = SQ_W'(1);
               found_in = 1'b0;
            end
         end
         S_NY:  ny_in   = mul_p[NY_W-1:0];
         S_SQX: prod_in = mul_p;
         S_CMP: begin
            // advance to c+1: (c+1)^2 = c^2 + 2c + 1
            if (!cond && c_ff != n_ff) begin
               c_in  = c_ff + CHUNK_W'(1);
               sq_in = sq_ff + SQ_W'({c_ff, 1'b1});
            end
         end
         S_DIVC: begin
            if (div_rsp.done) begin
               if (div_rsp.remainder == '0) begin
                  found_in = 1'b1;
                  gx_in    = div_rsp.quotient[CHUNK_W-1:0];
                  gy_in    = c_ff;
               end else begin
                  c_in = c_ff + CHUNK_W'(1);
               end
            end
         end
         S_PICK: begin
            // fall back to a strip split when no proper divisor fits
            if (!found_ff || gy_ff == n_ff) begin
               if (x_ff >= y_ff) begin
                  gx_in = n_ff;
                  gy_in = CHUNK_W'(1);
               end else begin
                  gx_in = CHUNK_W'(1);
                  gy_in = n_ff;
               end
            end
         end
         S_CHK: ok_in = t_lt_n;
         S_DX: begin
            if (div_rsp.done) begin
               dx_in = div_rsp.quotient;
               mx_in = div_rsp.remainder;
            end
         end
         S_DY: begin
            if (div_rsp.done) begin
               dy_in = div_rsp.quotient;
               my_in = div_rsp.remainder;
            end
         end
         S_DT: begin
            if (div_rsp.done) begin
               q_in = div_rsp.quotient[TASK_W-1:0];
               r_in = div_rsp.remainder[TASK_W-1:0];
            end
         end
         S_ML: prod_in = mul_p;
         S_MB: begin
            left_in = prod_ff[CELL_BITS-1:0] + CELL_BITS'(1) + CELL_BITS'(min_x);
            prod_in = mul_p;
         end
         S_MG: begin
            bottom_in = prod_ff[CELL_BITS-1:0] + CELL_BITS'(1) + CELL_BITS'(min_y);
            prod_in   = mul_p;
         end
         S_FIN: base_in = prod_ff[NEAR_W-1:0] + NEAR_W'(r_ff) + NEAR_W'(1);
         S_OUT: ;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load)
         rsp_valid_in = 1'b1;
      else if (rsp_bus.ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         chunk_ff     <= CHUNK_W'(1);
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         if (csr_bus.valid)
            chunk_ff <= csr_bus.chunk_count;
      end
      x_ff      <= x_in;
      y_ff      <= y_in;
      t_ff      <= t_in;
      n_ff      <= n_in;
      c_ff      <= c_in;
      sq_ff     <= sq_in;
      ny_ff     <= ny_in;
      prod_ff   <= prod_in;
      gx_ff     <= gx_in;
      gy_ff     <= gy_in;
      ok_ff     <= ok_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      mx_ff     <= mx_in;
      my_ff     <= my_in;
      q_ff      <= q_in;
      r_ff      <= r_in;
      left_ff   <= left_in;
      bottom_ff <= bottom_in;
      base_ff   <= base_in;
      if (rsp_load) begin
         o_cols_ff   <= gx_ff;
         o_rows_ff   <= gy_ff;
         o_ok_ff     <= ok_ff;
         o_left_ff   <= ok_ff ? left_ff   : '0;
         o_right_ff  <= ok_ff ? right_val : '0;
         o_bottom_ff <= ok_ff ? bottom_ff : '0;
         o_top_ff    <= ok_ff ? top_val   : '0;
         o_nl_ff     <= ok_ff ? nl_val    : '0;
         o_nr_ff     <= ok_ff ? nr_val    : '0;
         o_nb_ff     <= ok_ff ? nb_val    : '0;
         o_nt_ff     <= ok_ff ? nt_val    : '0;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.range_left   = o_left_ff;
   assign rsp_bus.range_right  = o_right_ff;
   assign rsp_bus.range_bottom = o_bottom_ff;
   assign rsp_bus.range_top    = o_top_ff;
   assign rsp_bus.near_left    = $signed(o_nl_ff);
   assign rsp_bus.near_right   = $signed(o_nr_ff);
   assign rsp_bus.near_bottom  = $signed(o_nb_ff);
   assign rsp_bus.near_top     = $signed(o_nt_ff);
   assign rsp_bus.grid_cols    = o_cols_ff;
   assign rsp_bus.grid_rows    = o_rows_ff;
   assign rsp_bus.task_ok      = o_ok_ff;

`ifndef NO_ASSERTIONS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_NY)
      else $error("accepted request did not start the search");
   a_grid_product: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT |->
         (2*CHUNK_W)'(gx_ff) * (2*CHUNK_W)'(gy_ff) == (2*CHUNK_W)'(n_ff))
      else $error("chosen grid does not cover the chunk count");
   a_bad_task_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !o_ok_ff |->
         o_left_ff == '0 && o_top_ff == '0 && o_nl_ff == '0 && o_nt_ff == '0)
      else $error("invalid task response carries nonzero range");
`endif

endmodule
